// ===== src/jfp_pkg.sv =====
package jfp_pkg;

	// Default signed width of the parsed values
	localparam int VALUE_WIDTH_DEF = 16;

	// Position reported after reset (clamped to the value range)
	localparam longint RESET_POS = 512;

	// Output field width of pos_x / pos_y
	localparam int POS_WIDTH = 16;

	// Received byte codes
	localparam logic [7:0] CH_STX   = 8'h02;
	localparam logic [7:0] CH_ETX   = 8'h03;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_TWO   = 8'h32;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_D     = 8'h44;

	// Event codes
	localparam logic [1:0] EV_POS   = 2'd0;
	localparam logic [1:0] EV_MODE0 = 2'd1;
	localparam logic [1:0] EV_MODE1 = 2'd2;
	localparam logic [1:0] EV_READ  = 2'd3;

	// Frame phase
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_X    = 2'd1;
	localparam logic [1:0] PH_Y    = 2'd2;

	// Field sub-phase
	localparam logic [1:0] SUB_LEAD  = 2'd0;
	localparam logic [1:0] SUB_DIGIT = 2'd1;
	localparam logic [1:0] SUB_DONE  = 2'd2;

	// Control from the frame logic to one field parser
	typedef struct packed {
		logic clr;  // drop partial field
		logic en;   // byte belongs to this field
	} field_ctl_t;

endpackage

// ===== src/jfp_field.sv =====
module jfp_field #(
	parameter int VALUE_WIDTH = jfp_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  jfp_pkg::field_ctl_t           ctl,
	input  logic [7:0]                    rx_byte,
	output logic signed [VALUE_WIDTH-1:0] value
);
	import jfp_pkg::*;

	localparam int EW = VALUE_WIDTH + 5;
	localparam logic signed [EW-1:0] MAX_E = EW'((longint'(1) <<< (VALUE_WIDTH - 1)) - 1);
	localparam logic signed [EW-1:0] MIN_E = EW'(-(longint'(1) <<< (VALUE_WIDTH - 1)));

	logic [1:0]                    sub_q, sub_d;
	logic                          neg_q, neg_d;
	logic signed [VALUE_WIDTH-1:0] acc_q, acc_d;

	logic                 is_digit, is_ws, is_sign, take;
	logic [3:0]           dig;
	logic signed [EW-1:0] acc_e, prod, dig_e, sum, sat;

	assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
	assign is_ws    = (rx_byte == CH_SPACE) || ((rx_byte >= CH_TAB) && (rx_byte <= CH_CR));
	assign is_sign  = (rx_byte == CH_PLUS) || (rx_byte == CH_MINUS);
	assign dig      = 4'(rx_byte - CH_ZERO);

	// acc * 10 -/+ digit, clamped to the signed range
	assign acc_e = EW'(acc_q);
	assign prod  = (acc_e <<< 3) + (acc_e <<< 1);
	assign dig_e = EW'(dig);
	assign sum   = neg_q ? (prod - dig_e) : (prod + dig_e);

	always_comb begin
		if (sum > MAX_E) begin
			sat = MAX_E;
		end else if (sum < MIN_E) begin
			sat = MIN_E;
		end else begin
			sat = sum;
		end
	end

	always_comb begin
		sub_d = sub_q;
		neg_d = neg_q;
		take  = 1'b0;
		case (sub_q)
			SUB_LEAD: begin
				if (is_ws) begin
					sub_d = sub_q;
				end else if (is_sign) begin
					neg_d = (rx_byte == CH_MINUS);
					sub_d = SUB_DIGIT;
				end else if (is_digit) begin
					sub_d = SUB_DIGIT;
					take  = 1'b1;
				end else begin
					sub_d = SUB_DONE;
				end
			end
			SUB_DIGIT: begin
				if (is_digit) begin
					take = 1'b1;
				end else begin
					sub_d = SUB_DONE;
				end
			end
			default: begin
				sub_d = sub_q;
			end
		endcase
		acc_d = take ? sat[VALUE_WIDTH-1:0] : acc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q <= SUB_LEAD;
			neg_q <= 1'b0;
			acc_q <= '0;
		end else if (ctl.clr) begin
			sub_q <= SUB_LEAD;
			neg_q <= 1'b0;
			acc_q <= '0;
		end else if (ctl.en) begin
			sub_q <= sub_d;
			neg_q <= neg_d;
			acc_q <= acc_d;
		end
	end

	assign value = acc_q;

endmodule

// ===== src/joystick_frame_parser_top.sv =====
// A byte accepted into the input register is parsed from there into the result register,
// which drives out_valid.
// Throughput: one byte per cycle; the input stalls only while the result register is
// full and stalled and the input register holds a byte.
// Reset (arst_n low, asynchronous): pipeline empty, frame cleared, mode 0,
// stored X and Y at 512 (clamped to the value range for narrow widths).
module joystick_frame_parser_top #(
	parameter int VALUE_WIDTH = jfp_pkg::VALUE_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] event_res,
	output logic [jfp_pkg::POS_WIDTH-1:0] pos_x,
	output logic [jfp_pkg::POS_WIDTH-1:0] pos_y,
	output logic       mode_now
);
	import jfp_pkg::*;

	localparam longint LIM_MAX = (longint'(1) <<< (VALUE_WIDTH - 1)) - 1;
	localparam logic signed [VALUE_WIDTH-1:0] RST_POS =
		VALUE_WIDTH'((RESET_POS > LIM_MAX) ? LIM_MAX : RESET_POS);

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Parser state
	logic       after_q;
	logic [1:0] phase_q;
	logic signed [VALUE_WIDTH-1:0] stored_x_q, stored_y_q;
	logic       mode_q;

	// Result register
	logic       out_valid_q;
	logic [1:0] event_q;
	logic [POS_WIDTH-1:0] pos_x_q, pos_y_q;
	logic       mode_out_q;

	logic advance, fire;
	field_ctl_t ctl_x, ctl_y;
	logic signed [VALUE_WIDTH-1:0] acc_x, acc_y;

	// Next-state of the frame logic for the byte in s1
	logic       after_d, mode_d, clr, emit, store;
	logic [1:0] phase_d, ev_d;
	logic       en_x, en_y;
	logic signed [VALUE_WIDTH-1:0] nx_x, nx_y;

	// Output register frees when empty or taken this cycle
	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	always_comb begin
		after_d = 1'b0;
		mode_d  = mode_q;
		phase_d = phase_q;
		clr     = 1'b0;
		emit    = 1'b0;
		store   = 1'b0;
		ev_d    = EV_POS;
		en_x    = 1'b0;
		en_y    = 1'b0;
		if (byte_s1 == CH_D) begin
			// button command armed, partial frame dropped
			clr     = 1'b1;
			after_d = 1'b1;
		end else if (after_q && (byte_s1 == CH_ZERO)) begin
			clr    = 1'b1;
			mode_d = 1'b0;
			emit   = 1'b1;
			ev_d   = EV_MODE0;
		end else if (after_q && (byte_s1 == CH_ONE)) begin
			clr    = 1'b1;
			mode_d = 1'b1;
			emit   = 1'b1;
			ev_d   = EV_MODE1;
		end else if (after_q && (byte_s1 == CH_TWO)) begin
			clr  = 1'b1;
			emit = 1'b1;
			ev_d = EV_READ;
		end else if (byte_s1 == CH_ETX) begin
			// frame complete only once STX and comma were both seen
			clr   = 1'b1;
			store = (phase_q == PH_Y);
			emit  = (phase_q == PH_Y);
		end else begin
			case (phase_q)
				PH_IDLE: begin
					if (byte_s1 == CH_STX) begin
						phase_d = PH_X;
					end
				end
				PH_X: begin
					if (byte_s1 == CH_COMMA) begin
						phase_d = PH_Y;
					end else begin
						en_x = 1'b1;
					end
				end
				default: begin
					en_y = 1'b1;
				end
			endcase
		end
		if (clr) begin
			phase_d = PH_IDLE;
		end
		nx_x = store ? acc_x : stored_x_q;
		nx_y = store ? acc_y : stored_y_q;
	end

	assign ctl_x = '{clr: fire && clr, en: fire && en_x};
	assign ctl_y = '{clr: fire && clr, en: fire && en_y};

	jfp_field #(.VALUE_WIDTH(VALUE_WIDTH)) u_field_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl_x),
		.rx_byte (byte_s1),
		.value   (acc_x)
	);

	jfp_field #(.VALUE_WIDTH(VALUE_WIDTH)) u_field_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl_y),
		.rx_byte (byte_s1),
		.value   (acc_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			after_q    <= 1'b0;
			phase_q    <= PH_IDLE;
			stored_x_q <= RST_POS;
			stored_y_q <= RST_POS;
			mode_q     <= 1'b0;
		end else if (fire) begin
			after_q    <= after_d;
			phase_q    <= phase_d;
			stored_x_q <= nx_x;
			stored_y_q <= nx_y;
			mode_q     <= mode_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fire && emit;
		end
	end

	// Values are zero-extended below 16 bits, truncated above
	always_ff @(posedge clk) begin
		if (fire && emit) begin
			event_q    <= ev_d;
			pos_x_q    <= POS_WIDTH'($unsigned(nx_x));
			pos_y_q    <= POS_WIDTH'($unsigned(nx_y));
			mode_out_q <= mode_d;
		end
	end

	assign out_valid = out_valid_q;
	assign event_res = event_q;
	assign pos_x     = pos_x_q;
	assign pos_y     = pos_y_q;
	assign mode_now  = mode_out_q;

endmodule

// ===== src/jfp_checker.sv =====
module jfp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] event_res,
	input logic [jfp_pkg::POS_WIDTH-1:0] pos_x,
	input logic [jfp_pkg::POS_WIDTH-1:0] pos_y,
	input logic       mode_now
);
	import jfp_pkg::*;

	// Empty result register never backs up the input
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	a_mode0_event: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (event_res == EV_MODE0)) |-> !mode_now)
		else $error("mode zero event with mode one");

	a_mode1_event: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (event_res == EV_MODE1)) |-> mode_now)
		else $error("mode one event with mode zero");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(pos_x) && $stable(pos_y)
			&& $stable(event_res) && $stable(mode_now)))
		else $error("stalled item changed");

endmodule

bind joystick_frame_parser_top jfp_checker u_jfp_checker (.*);

// ===== sim/tb_joystick_frame_parser_top.sv =====
module tb_joystick_frame_parser_top;

	import jfp_pkg::*;

	// Signed saturation limits of the parsed values at the default width
	localparam int VAL_MAX = (1 <<< (VALUE_WIDTH_DEF - 1)) - 1;
	localparam int VAL_MIN = -(1 <<< (VALUE_WIDTH_DEF - 1));

	// Abort when no handshake happens on either side for this many cycles;
	// the longest legal silence is the forced output hold
	localparam int WATCHDOG_LIMIT = 4000;

	// Receiver hold-off used to back the pipeline up into the input
	localparam int HOLD_AT_BYTE = 400;
	localparam int HOLD_CYCLES  = 80;

	// Idling stops once fewer than this many bytes are still queued
	localparam int TAIL_BYTES = 120;

	localparam int STIM_BYTES = 850;

	// One expected report: event code plus the stored values it carries
	typedef struct packed {
		logic [1:0]           ev;
		logic [POS_WIDTH-1:0] x;
		logic [POS_WIDTH-1:0] y;
		logic                 m;
	} joy_report_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	logic [7:0]           rx_byte   = 8'h00;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [1:0]           event_res;
	logic [POS_WIDTH-1:0] pos_x;
	logic [POS_WIDTH-1:0] pos_y;
	logic                 mode_now;

	joystick_frame_parser_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.rx_byte   (rx_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.event_res (event_res),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.mode_now  (mode_now)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Bytes still to send (head is the one on the bus) and reports still owed
	logic [7:0]  tx_bytes[$];
	joy_report_t pending_reports[$];

	int err_cnt      = 0;
	int bytes_in     = 0;
	int reports_seen = 0;
	int quiet_cycles = 0;
	int send_gap     = 0;
	int recv_gap     = 0;
	int hold_left    = 0;
	bit hold_done    = 1'b0;
	bit tail_phase   = 1'b0;

	// ------------------------------------------------------------------
	// Parser shadow state. Field index 0 is X, 1 is Y.
	// ------------------------------------------------------------------
	bit                          cmd_armed;
	logic [1:0]                  frame_ph;
	logic [1:0]                  fld_sub[2];
	bit                          fld_neg[2];
	int                          fld_acc[2];
	logic signed [POS_WIDTH-1:0] kept_x;
	logic signed [POS_WIDTH-1:0] kept_y;
	logic                        mode_sel;

	task automatic drop_partial_frame();
		frame_ph = PH_IDLE;
		for (int f = 0; f < 2; f++) begin
			fld_sub[f] = SUB_LEAD;
			fld_neg[f] = 1'b0;
			fld_acc[f] = 0;
		end
	endtask

	// atol-style digit gathering with saturation
	task automatic field_step(input logic [7:0] b, input int f);
		bit     digit;
		bit     skip;
		longint v;
		digit = (b >= CH_ZERO) && (b <= CH_NINE);
		skip  = 1'b0;
		if (fld_sub[f] == SUB_LEAD) begin
			if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR)) begin
				skip = 1'b1;
			end else if (b == CH_PLUS || b == CH_MINUS) begin
				fld_neg[f] = (b == CH_MINUS);
				fld_sub[f] = SUB_DIGIT;
				skip = 1'b1;
			end else begin
				fld_sub[f] = digit ? SUB_DIGIT : SUB_DONE;
			end
		end
		if (!skip && fld_sub[f] == SUB_DIGIT) begin
			if (!digit) begin
				fld_sub[f] = SUB_DONE;
			end else begin
				v = longint'(fld_acc[f]) * 10;
				v = fld_neg[f] ? v - longint'(b - CH_ZERO) : v + longint'(b - CH_ZERO);
				if (v > VAL_MAX) v = VAL_MAX;
				if (v < VAL_MIN) v = VAL_MIN;
				fld_acc[f] = int'(v);
			end
		end
	endtask

	// Advance the shadow parser by one accepted byte; queue the report it owes
	task automatic parse_rx_byte(input logic [7:0] b);
		joy_report_t r;
		bit          gives;
		gives = 1'b0;
		r.ev  = EV_POS;
		if (b == CH_D) begin
			drop_partial_frame();
			cmd_armed = 1'b1;
		end else if (cmd_armed && (b == CH_ZERO || b == CH_ONE || b == CH_TWO)) begin
			cmd_armed = 1'b0;
			drop_partial_frame();
			gives = 1'b1;
			if (b == CH_ZERO) begin
				mode_sel = 1'b0;
				r.ev = EV_MODE0;
			end else if (b == CH_ONE) begin
				mode_sel = 1'b1;
				r.ev = EV_MODE1;
			end else begin
				r.ev = EV_READ;
			end
		end else begin
			cmd_armed = 1'b0;
			if (b == CH_ETX) begin
				if (frame_ph == PH_Y) begin
					kept_x = POS_WIDTH'(fld_acc[0]);
					kept_y = POS_WIDTH'(fld_acc[1]);
					gives = 1'b1;
					r.ev = EV_POS;
				end
				drop_partial_frame();
			end else if (frame_ph == PH_IDLE) begin
				if (b == CH_STX) frame_ph = PH_X;
			end else if (frame_ph == PH_X) begin
				if (b == CH_COMMA) frame_ph = PH_Y;
				else field_step(b, 0);
			end else begin
				field_step(b, 1);
			end
		end
		if (gives) begin
			r.x = kept_x;
			r.y = kept_y;
			r.m = mode_sel;
			pending_reports.push_back(r);
		end
	endtask

	// ------------------------------------------------------------------
	// Stimulus building
	// ------------------------------------------------------------------
	task automatic push_str(input string s);
		for (int i = 0; i < s.len(); i++) tx_bytes.push_back(s[i]);
	endtask

	function automatic logic [7:0] pick_space();
		int w;
		w = $urandom_range(0, 5);
		return (w == 5) ? CH_SPACE : CH_TAB + 8'(w);
	endfunction

	// Well-formed field text with random padding, sign, length and a stray tail
	task automatic add_field();
		int         n;
		logic [7:0] junk;
		repeat ($urandom_range(0, 2)) tx_bytes.push_back(pick_space());
		case ($urandom_range(0, 3))
			0: tx_bytes.push_back(CH_PLUS);
			1: tx_bytes.push_back(CH_MINUS);
			default: ;
		endcase
		// mostly short numbers, now and then long enough to saturate
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 8) : $urandom_range(0, 5);
		repeat (n) tx_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
		if ($urandom_range(0, 4) == 0) begin
			junk = 8'($urandom_range(0, 255));
			if (junk == CH_D || junk == CH_ETX) junk = CH_SPACE;
			tx_bytes.push_back(junk);
		end
	endtask

	initial begin : stimulus
		int k;
		cmd_armed = 1'b0;
		drop_partial_frame();
		kept_x   = POS_WIDTH'(RESET_POS > VAL_MAX ? VAL_MAX : RESET_POS);
		kept_y   = kept_x;
		mode_sel = 1'b0;

		// Directed: stray bytes before any frame start, all bits of the byte
		tx_bytes.push_back(8'h00);
		tx_bytes.push_back(8'hFF);
		// the three button commands, then a D followed by an ordinary byte
		push_str("D0D1D2Dx");
		// frame end with no comma: dropped
		tx_bytes.push_back(CH_STX);
		tx_bytes.push_back(CH_ETX);
		// negative overflow in X, lone sign in Y
		tx_bytes.push_back(CH_STX);
		push_str("\t-99999,+");
		tx_bytes.push_back(CH_ETX);
		// repeated start byte ends the X digits; positive overflow in Y
		tx_bytes.push_back(CH_STX);
		push_str("5");
		tx_bytes.push_back(CH_STX);
		push_str(",+40000");
		tx_bytes.push_back(CH_ETX);
		// a D in the middle of a frame wipes it, then a readout request
		tx_bytes.push_back(CH_STX);
		push_str("12D2");

		// Random: mostly complete frames, some commands, broken frames and noise
		while (tx_bytes.size() < STIM_BYTES) begin
			k = $urandom_range(0, 19);
			if (k < 13) begin
				repeat ($urandom_range(0, 1)) tx_bytes.push_back(8'($urandom_range(0, 255)));
				tx_bytes.push_back(CH_STX);
				add_field();
				tx_bytes.push_back(CH_COMMA);
				add_field();
				tx_bytes.push_back(CH_ETX);
			end else if (k < 16) begin
				tx_bytes.push_back(CH_D);
				case ($urandom_range(0, 3))
					0: tx_bytes.push_back(CH_ZERO);
					1: tx_bytes.push_back(CH_ONE);
					2: tx_bytes.push_back(CH_TWO);
					default: tx_bytes.push_back(8'($urandom_range(0, 255)));
				endcase
			end else if (k < 18) begin
				// frame cut short: no comma, or a command in the middle
				tx_bytes.push_back(CH_STX);
				add_field();
				if (k == 17) push_str("D1");
				tx_bytes.push_back(CH_ETX);
			end else begin
				repeat ($urandom_range(1, 4)) tx_bytes.push_back(8'($urandom_range(0, 255)));
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		wait (tx_bytes.size() == 0 && pending_reports.size() == 0);
		// run on past the two pipeline stages to catch extra reports
		repeat (8) @(posedge clk);
		if (err_cnt == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// ------------------------------------------------------------------
	// Byte driver. The head of tx_bytes stays on the bus until accepted;
	// a stalled byte is never changed. Idle bursts only outside the tail
	// and outside the forced output hold, so the hold really fills the block.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : byte_driver
		logic       nv;
		logic [7:0] nb;
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte  <= 8'h00;
		end else begin
			nv = in_valid;
			nb = rx_byte;
			if (in_valid && !in_stall) begin
				parse_rx_byte(rx_byte);
				void'(tx_bytes.pop_front());
				bytes_in <= bytes_in + 1;
			end
			if (!(in_valid && in_stall)) begin
				nv = 1'b0;
				if (send_gap > 0) begin
					send_gap--;
				end else if (tx_bytes.size() > 0) begin
					// every third stretch of 64 bytes runs back to back
					if (!tail_phase && hold_left == 0 && ((bytes_in / 64) % 3 != 0) &&
					    $urandom_range(0, 7) == 0) begin
						send_gap = $urandom_range(0, 8);
					end else begin
						nv = 1'b1;
						nb = tx_bytes[0];
					end
				end
			end
			in_valid   <= nv;
			rx_byte    <= nb;
			tail_phase <= (tx_bytes.size() < TAIL_BYTES);
		end
	end

	// ------------------------------------------------------------------
	// Report monitor and output stall generator
	// ------------------------------------------------------------------
	task automatic check_field(input string what, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			err_cnt++;
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : report_monitor
		joy_report_t want;
		logic        ns;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				reports_seen <= reports_seen + 1;
				if (pending_reports.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected report, expected none actual ev=%0d x=%0d y=%0d m=%0b",
					         $time, event_res, $signed(pos_x), $signed(pos_y), mode_now);
				end else begin
					want = pending_reports.pop_front();
					check_field("event_res", 16'(want.ev), 16'(event_res));
					check_field("pos_x", want.x, pos_x);
					check_field("pos_y", want.y, pos_y);
					check_field("mode_now", 16'(want.m), 16'(mode_now));
				end
			end
			// long hold-off once, mid-run, while the driver keeps offering bytes
			if (!hold_done && bytes_in >= HOLD_AT_BYTE) begin
				hold_done = 1'b1;
				hold_left <= HOLD_CYCLES;
				ns = 1'b1;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				ns = 1'b1;
			end else if (recv_gap > 0) begin
				recv_gap--;
				ns = 1'b1;
			end else if (!tail_phase && ((bytes_in / 48) % 3 != 1) &&
			             $urandom_range(0, 5) == 0) begin
				recv_gap = $urandom_range(0, 8);
				ns = 1'b1;
			end else begin
				ns = 1'b0;
			end
			out_stall <= ns;
		end
	end

	// Watchdog: cycles without any handshake on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no progress, %0d reports still owed", $time, pending_reports.size());
				$display("Test completed with failures");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

endmodule

// ===== joystick_frame_parser_top.f =====
src/jfp_pkg.sv
src/jfp_field.sv
src/joystick_frame_parser_top.sv
src/jfp_checker.sv
sim/tb_joystick_frame_parser_top.sv
